// File: rtl/core/bcl_pkg.sv
// Package for the cubic Bezier point and length core.
// Holds field widths, sequencer states, step codes and fixed constants.
// No dependencies.
`default_nettype none
package bcl_pkg;

    localparam int COORD_W = 24;
    localparam int T_W     = 17;
    localparam int LEN_W   = 27;
    localparam int W_W     = 18;  // rounded Bernstein weight
    localparam int ACC_W   = 46;  // coordinate sum before rounding
    localparam int MA_W    = 36;  // shared multiplier operand A
    localparam int MB_W    = 25;  // shared multiplier operand B
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SQ_W    = 51;  // sum of squared chord deltas
    localparam int ROOT_W  = 25;

    localparam int SAMPLES_DEFAULT = 1000;
    localparam int ONE_Q16         = 65536;

    localparam logic [T_W-1:0]     T_ONE   = 17'd65536;
    localparam logic [LEN_W:0]     LEN_MAX = 28'd134217727;
    localparam logic [SQ_W-1:0]    ROOT_TOP_BIT = 51'd1 << 50;

    localparam logic signed [ACC_W-1:0] PT_MAX = 46'sd8388607;
    localparam logic signed [ACC_W-1:0] PT_MIN = -46'sd8388608;

    // multiply sequence: issue at step s, product consumed at step s+1
    localparam logic [4:0] ST_UU     = 5'd1;
    localparam logic [4:0] ST_TT     = 5'd2;
    localparam logic [4:0] ST_W0     = 5'd3;
    localparam logic [4:0] ST_W3     = 5'd4;
    localparam logic [4:0] ST_W1     = 5'd5;
    localparam logic [4:0] ST_W2     = 5'd6;
    localparam logic [4:0] ST_X0     = 5'd7;
    localparam logic [4:0] ST_Y0     = 5'd11;
    localparam logic [4:0] ST_Z0     = 5'd15;
    localparam logic [4:0] MUL_LAST  = 5'd18;
    localparam logic [4:0] SQ_LAST   = 5'd3;
    localparam logic [4:0] ROOT_LAST = 5'd25;

    localparam logic MODE_POINT  = 1'b0;
    localparam logic MODE_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_MUL,
        S_POINT,
        S_SQ,
        S_ROOT,
        S_ACC,
        S_FIN
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/bcl_seg_if.sv
// Input channel carrying one Bezier segment word.
// Depends on bcl_pkg for field widths.
`default_nettype none
interface bcl_seg_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic [bcl_pkg::T_W-1:0]              t_fraction;
    logic signed [bcl_pkg::COORD_W-1:0]   start_x;
    logic signed [bcl_pkg::COORD_W-1:0]   start_y;
    logic signed [bcl_pkg::COORD_W-1:0]   start_z;
    logic signed [bcl_pkg::COORD_W-1:0]   first_ctrl_x;
    logic signed [bcl_pkg::COORD_W-1:0]   first_ctrl_y;
    logic signed [bcl_pkg::COORD_W-1:0]   second_ctrl_x;
    logic signed [bcl_pkg::COORD_W-1:0]   second_ctrl_y;
    logic signed [bcl_pkg::COORD_W-1:0]   end_x;
    logic signed [bcl_pkg::COORD_W-1:0]   end_y;
    logic signed [bcl_pkg::COORD_W-1:0]   end_z;

    modport source (output valid, mode, t_fraction, start_x, start_y, start_z,
                    first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y,
                    end_x, end_y, end_z, input ready);
    modport sink (input valid, mode, t_fraction, start_x, start_y, start_z,
                  first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y,
                  end_x, end_y, end_z, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bcl_res_if.sv
// Output channel carrying one point or length result word.
// Depends on bcl_pkg for field widths.
`default_nettype none
interface bcl_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bcl_pkg::COORD_W-1:0]   point_x;
    logic signed [bcl_pkg::COORD_W-1:0]   point_y;
    logic signed [bcl_pkg::COORD_W-1:0]   point_z;
    logic [bcl_pkg::LEN_W-1:0]            curve_length;
    logic                                 length_saturated;

    modport source (output valid, point_x, point_y, point_z, curve_length,
                    length_saturated, input ready);
    modport sink (input valid, point_x, point_y, point_z, curve_length,
                  length_saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cubic_bezier_point_and_length_core.sv
// Cubic Bezier point / chord-length core, single shared multiplier.
// Depends on bcl_pkg, bcl_seg_if and bcl_res_if.
//
// Usage: the seg channel takes one segment word (valid/ready); the res
// channel returns exactly one result word per segment.
// Mode 0 returns the curve point at t_fraction (clamped to 1.0), with
// curve_length and length_saturated zero. Mode 1 returns the chord-sum
// length over SAMPLES steps, with the point fields zero.
// All products go through one 36x25 multiplier with a registered output;
// the chord root runs one result bit per cycle.
// Sequence: mode 0 runs 19 multiply steps, one rounding state and the output
// load after the segment is taken. Mode 1 runs, for each sample, 19 multiply
// steps for the point, 4 for the squares, 26 for the root and 3 control states,
// then the output load.
// seg.ready is high only while the core is idle; a finished word waits in
// the output register while the next segment may already be accepted, so
// the next segment can be taken in the cycle after the result is loaded.
// If res stalls, the core holds its finished word until the register is
// free. Reset clears the sequencer and the output valid; no sweep.
`default_nettype none
module cubic_bezier_point_and_length_core #(
    parameter int SAMPLES = bcl_pkg::SAMPLES_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bcl_seg_if.sink    seg,
    bcl_res_if.source  res
);
    localparam int I_W   = $clog2(SAMPLES + 1);
    localparam int R_W   = $clog2(2 * SAMPLES);
    localparam int STEP_A = bcl_pkg::ONE_Q16 / SAMPLES;
    localparam int STEP_B = bcl_pkg::ONE_Q16 % SAMPLES;
    localparam int HALF   = SAMPLES / 2;
    localparam int CW     = bcl_pkg::COORD_W;
    localparam int TW     = bcl_pkg::T_W;

    bcl_pkg::state_t state_reg, state_next;

    logic [4:0]     step_reg, step_next;
    logic [I_W-1:0] idx_reg, idx_next;
    logic [R_W-1:0] rem_t_reg, rem_t_next;
    logic [TW-1:0]  t_reg, t_next;
    logic           mode_reg, mode_next;

    logic signed [CW-1:0] sx_reg, sy_reg, sz_reg, ax_reg, ay_reg;
    logic signed [CW-1:0] bx_reg, by_reg, ex_reg, ey_reg, ez_reg;
    logic signed [CW-1:0] px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic signed [CW-1:0] lx_reg, ly_reg, lz_reg, lx_next, ly_next, lz_next;

    logic [33:0] uu_reg, uu_next, tt_reg, tt_next;
    logic [bcl_pkg::W_W-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [bcl_pkg::W_W-1:0] w0_next, w1_next, w2_next, w3_next;
    logic signed [bcl_pkg::ACC_W-1:0] accx_reg, accy_reg, accz_reg;
    logic signed [bcl_pkg::ACC_W-1:0] accx_next, accy_next, accz_next;

    logic [bcl_pkg::SQ_W-1:0] rem_reg, rem_next, root_reg, root_next;
    logic [bcl_pkg::SQ_W-1:0] bit_reg, bit_next, trial;
    logic [bcl_pkg::LEN_W-1:0] sum_reg, sum_next;
    logic sat_reg, sat_next;

    logic signed [bcl_pkg::MA_W-1:0]   mul_a;
    logic signed [bcl_pkg::MB_W-1:0]   mul_b;
    logic signed [bcl_pkg::PROD_W-1:0] prod_reg;

    logic out_valid_reg;
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;
    logic [bcl_pkg::LEN_W-1:0] olen_reg;
    logic osat_reg;

    logic seg_fire, fin_load;
    logic [TW-1:0] u_val;
    logic [18:0]   t3, u3;
    logic [bcl_pkg::W_W-1:0] w_round;
    logic signed [bcl_pkg::ACC_W-1:0] prod_acc;
    logic [24:0] dx, dy, dz;
    logic [R_W:0] rem_t_sum;
    logic [bcl_pkg::LEN_W:0] sum_wide;

    assign seg.ready = (state_reg == bcl_pkg::S_IDLE);
    assign seg_fire  = seg.valid && seg.ready;
    assign fin_load  = (state_reg == bcl_pkg::S_FIN) && (!out_valid_reg || res.ready);

    assign u_val = bcl_pkg::T_ONE - t_reg;
    assign t3 = 19'({t_reg, 1'b0}) + 19'(t_reg);
    assign u3 = 19'({u_val, 1'b0}) + 19'(u_val);
    assign w_round = bcl_pkg::W_W'((prod_reg[49:0] + 50'd2147483648) >> 32);
    assign prod_acc = prod_reg[bcl_pkg::ACC_W-1:0];
    assign trial = root_reg + bit_reg;
    assign rem_t_sum = (R_W+1)'(rem_t_reg) + (R_W+1)'(STEP_B);
    assign sum_wide = (bcl_pkg::LEN_W+1)'(sum_reg) + (bcl_pkg::LEN_W+1)'(root_reg[24:0]);

    function automatic logic [24:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
        logic signed [24:0] d;
        d = 25'(a) - 25'(b);
        return d[24] ? 25'(-d) : 25'(d);
    endfunction

    function automatic logic signed [CW-1:0] round_sat(
        input logic signed [bcl_pkg::ACC_W-1:0] acc);
        logic signed [bcl_pkg::ACC_W-1:0] r;
        r = (acc + 46'sd32768) >>> 16;
        if (r > bcl_pkg::PT_MAX)
            return bcl_pkg::PT_MAX[CW-1:0];
        else if (r < bcl_pkg::PT_MIN)
            return bcl_pkg::PT_MIN[CW-1:0];
        return r[CW-1:0];
    endfunction

    assign dx = abs_diff(px_reg, lx_reg);
    assign dy = abs_diff(py_reg, ly_reg);
    assign dz = abs_diff(pz_reg, lz_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == bcl_pkg::S_MUL)
        begin
            case (step_reg)
                5'd0:  begin mul_a = 36'(u_val);  mul_b = 25'(u_val); end
                5'd1:  begin mul_a = 36'(t_reg);  mul_b = 25'(t_reg); end
                5'd2:  begin mul_a = 36'(uu_reg); mul_b = 25'(u_val); end
                5'd3:  begin mul_a = 36'(tt_reg); mul_b = 25'(t_reg); end
                5'd4:  begin mul_a = 36'(uu_reg); mul_b = 25'(t3);    end
                5'd5:  begin mul_a = 36'(tt_reg); mul_b = 25'(u3);    end
                5'd6:  begin mul_a = 36'(sx_reg); mul_b = 25'(w0_reg); end
                5'd7:  begin mul_a = 36'(ax_reg); mul_b = 25'(w1_reg); end
                5'd8:  begin mul_a = 36'(bx_reg); mul_b = 25'(w2_reg); end
                5'd9:  begin mul_a = 36'(ex_reg); mul_b = 25'(w3_reg); end
                5'd10: begin mul_a = 36'(sy_reg); mul_b = 25'(w0_reg); end
                5'd11: begin mul_a = 36'(ay_reg); mul_b = 25'(w1_reg); end
                5'd12: begin mul_a = 36'(by_reg); mul_b = 25'(w2_reg); end
                5'd13: begin mul_a = 36'(ey_reg); mul_b = 25'(w3_reg); end
                5'd14: begin mul_a = 36'(sz_reg); mul_b = 25'(w0_reg); end
                5'd15: begin mul_a = 36'(sz_reg); mul_b = 25'(w1_reg); end
                5'd16: begin mul_a = 36'(sz_reg); mul_b = 25'(w2_reg); end
                5'd17: begin mul_a = 36'(ez_reg); mul_b = 25'(w3_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == bcl_pkg::S_SQ)
        begin
            case (step_reg)
                5'd0: begin mul_a = 36'(dx); mul_b = 25'(dx); end
                5'd1: begin mul_a = 36'(dy); mul_b = 25'(dy); end
                5'd2: begin mul_a = 36'(dz); mul_b = 25'(dz); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcl_pkg::S_IDLE:
                if (seg_fire)
                    state_next = (seg.mode == bcl_pkg::MODE_LENGTH) ?
                                 bcl_pkg::S_NEXT : bcl_pkg::S_MUL;
            bcl_pkg::S_NEXT:
                state_next = bcl_pkg::S_MUL;
            bcl_pkg::S_MUL:
                if (step_reg == bcl_pkg::MUL_LAST)
                    state_next = bcl_pkg::S_POINT;
            bcl_pkg::S_POINT:
                state_next = (mode_reg == bcl_pkg::MODE_LENGTH) ?
                             bcl_pkg::S_SQ : bcl_pkg::S_FIN;
            bcl_pkg::S_SQ:
                if (step_reg == bcl_pkg::SQ_LAST)
                    state_next = bcl_pkg::S_ROOT;
            bcl_pkg::S_ROOT:
                if (step_reg == bcl_pkg::ROOT_LAST)
                    state_next = bcl_pkg::S_ACC;
            bcl_pkg::S_ACC:
                state_next = (idx_reg == I_W'(SAMPLES)) ? bcl_pkg::S_FIN : bcl_pkg::S_NEXT;
            bcl_pkg::S_FIN:
                if (fin_load)
                    state_next = bcl_pkg::S_IDLE;
            default:
                state_next = bcl_pkg::S_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        step_next  = step_reg;
        idx_next   = idx_reg;
        rem_t_next = rem_t_reg;
        t_next     = t_reg;
        mode_next  = mode_reg;
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg;
        lx_next = lx_reg; ly_next = ly_reg; lz_next = lz_reg;
        uu_next = uu_reg; tt_next = tt_reg;
        w0_next = w0_reg; w1_next = w1_reg; w2_next = w2_reg; w3_next = w3_reg;
        accx_next = accx_reg; accy_next = accy_reg; accz_next = accz_reg;
        rem_next = rem_reg; root_next = root_reg; bit_next = bit_reg;
        sum_next = sum_reg; sat_next = sat_reg;
        case (state_reg)
            bcl_pkg::S_IDLE:
            begin
                step_next  = '0;
                idx_next   = '0;
                rem_t_next = R_W'(HALF);
                mode_next  = seg.mode;
                sum_next   = '0;
                sat_next   = 1'b0;
                lx_next = seg.start_x; ly_next = seg.start_y; lz_next = seg.start_z;
                if (seg.mode == bcl_pkg::MODE_LENGTH)
                    t_next = '0;
                else
                    t_next = (seg.t_fraction > bcl_pkg::T_ONE) ? bcl_pkg::T_ONE
                                                                : seg.t_fraction;
            end
            bcl_pkg::S_NEXT:
            begin
                // advance t_i = (i*65536 + SAMPLES/2) / SAMPLES incrementally
                step_next = '0;
                idx_next  = idx_reg + 1'b1;
                if (rem_t_sum >= (R_W+1)'(SAMPLES))
                begin
                    rem_t_next = R_W'(rem_t_sum - (R_W+1)'(SAMPLES));
                    t_next     = TW'(18'(t_reg) + 18'(STEP_A) + 18'd1);
                end
                else
                begin
                    rem_t_next = R_W'(rem_t_sum);
                    t_next     = TW'(18'(t_reg) + 18'(STEP_A));
                end
            end
            bcl_pkg::S_MUL:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    bcl_pkg::ST_UU: uu_next = prod_reg[33:0];
                    bcl_pkg::ST_TT: tt_next = prod_reg[33:0];
                    bcl_pkg::ST_W0: w0_next = w_round;
                    bcl_pkg::ST_W3: w3_next = w_round;
                    bcl_pkg::ST_W1: w1_next = w_round;
                    bcl_pkg::ST_W2: w2_next = w_round;
                    bcl_pkg::ST_X0: accx_next = prod_acc;
                    5'd8, 5'd9, 5'd10: accx_next = accx_reg + prod_acc;
                    bcl_pkg::ST_Y0: accy_next = prod_acc;
                    5'd12, 5'd13, 5'd14: accy_next = accy_reg + prod_acc;
                    bcl_pkg::ST_Z0: accz_next = prod_acc;
                    5'd16, 5'd17, 5'd18: accz_next = accz_reg + prod_acc;
                    default: ;
                endcase
            end
            bcl_pkg::S_POINT:
            begin
                step_next = '0;
                px_next = round_sat(accx_reg);
                py_next = round_sat(accy_reg);
                pz_next = round_sat(accz_reg);
            end
            bcl_pkg::S_SQ:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    5'd1: rem_next = prod_reg[bcl_pkg::SQ_W-1:0];
                    5'd2, 5'd3: rem_next = rem_reg + prod_reg[bcl_pkg::SQ_W-1:0];
                    default: ;
                endcase
                if (step_reg == bcl_pkg::SQ_LAST)
                    step_next = '0;
                root_next = '0;
                bit_next  = bcl_pkg::ROOT_TOP_BIT;
            end
            bcl_pkg::S_ROOT:
            begin
                step_next = step_reg + 1'b1;
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            bcl_pkg::S_ACC:
            begin
                if (sum_wide > bcl_pkg::LEN_MAX)
                begin
                    sum_next = bcl_pkg::LEN_MAX[bcl_pkg::LEN_W-1:0];
                    sat_next = 1'b1;
                end
                else
                    sum_next = sum_wide[bcl_pkg::LEN_W-1:0];
                lx_next = px_reg; ly_next = py_reg; lz_next = pz_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcl_pkg::S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rem_t_reg <= rem_t_next;
        t_reg     <= t_next;
        mode_reg  <= mode_next;
        if (seg_fire)
        begin
            sx_reg <= seg.start_x;       sy_reg <= seg.start_y;
            sz_reg <= seg.start_z;
            ax_reg <= seg.first_ctrl_x;  ay_reg <= seg.first_ctrl_y;
            bx_reg <= seg.second_ctrl_x; by_reg <= seg.second_ctrl_y;
            ex_reg <= seg.end_x;         ey_reg <= seg.end_y;
            ez_reg <= seg.end_z;
        end
        px_reg <= px_next; py_reg <= py_next; pz_reg <= pz_next;
        lx_reg <= lx_next; ly_reg <= ly_next; lz_reg <= lz_next;
        uu_reg <= uu_next; tt_reg <= tt_next;
        w0_reg <= w0_next; w1_reg <= w1_next; w2_reg <= w2_next; w3_reg <= w3_next;
        accx_reg <= accx_next; accy_reg <= accy_next; accz_reg <= accz_next;
        rem_reg  <= rem_next;  root_reg <= root_next; bit_reg <= bit_next;
        sum_reg  <= sum_next;  sat_reg  <= sat_next;
        prod_reg <= mul_a * mul_b;
        if (fin_load)
        begin
            if (mode_reg == bcl_pkg::MODE_LENGTH)
            begin
                ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
                olen_reg <= sum_reg;
                osat_reg <= sat_reg;
            end
            else
            begin
                ox_reg <= px_reg; oy_reg <= py_reg; oz_reg <= pz_reg;
                olen_reg <= '0;
                osat_reg <= 1'b0;
            end
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.point_x          = ox_reg;
    assign res.point_y          = oy_reg;
    assign res.point_z          = oz_reg;
    assign res.curve_length     = olen_reg;
    assign res.length_saturated = osat_reg;

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for cubic_bezier_point_and_length_core: a directed table, then random
// segments, checked against typed rows or an in-bench point and chord-length predictor.
// Depends on bcl_pkg, bcl_seg_if, bcl_res_if and the core RTL.
`default_nettype none
module tb;
    import bcl_pkg::*;

    // chord count of the core default; the predictor uses the same count
    localparam int CHORD_STEPS = SAMPLES_DEFAULT;
    // sized above a whole length word, during which no word moves on either channel
    localparam int STALL_LIMIT = 300000;
    localparam int RANDOM_WORDS = 300;
    localparam int DIR_ROWS = 12;
    localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] CMIN = -24'sh800000;

    typedef struct packed {
        logic                      mode;
        logic [T_W-1:0]            t;
        logic signed [COORD_W-1:0] sx, sy, sz, ax, ay, bx, by, ex, ey, ez;
    } seg_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px, py, pz;
        logic [LEN_W-1:0]          len;
        logic                      sat;
    } res_word_t;

    typedef struct packed {
        seg_word_t seg;
        logic      typed;
        res_word_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   quiet_cycles = 0;
    res_word_t pending_results[$];

    bcl_seg_if seg ();
    bcl_res_if res ();

    cubic_bezier_point_and_length_core #(.SAMPLES(CHORD_STEPS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg.sink),
        .res   (res.source)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // directed rows: typed expectations only where obvious
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{'{MODE_POINT, 17'd0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
          1'b1, '{CMIN, CMIN, CMIN, 27'd0, 1'b0}},
        '{'{MODE_POINT, 17'd65536, 24'sd0, 24'sd0, 24'sd0, CMIN, CMAX, CMAX, CMIN,
            CMAX, CMAX, CMAX},
          1'b1, '{CMAX, CMAX, CMAX, 27'd0, 1'b0}},
        '{'{MODE_POINT, 17'h1FFFF, 24'sd40, 24'sd50, 24'sd60, CMAX, CMIN, CMIN, CMAX,
            -24'sd5, 24'sd7, -24'sd9},
          1'b1, '{-24'sd5, 24'sd7, -24'sd9, 27'd0, 1'b0}},
        '{'{MODE_LENGTH, 17'd0, 24'sd100, 24'sd200, 24'sd300, 24'sd100, 24'sd200,
            24'sd100, 24'sd200, 24'sd100, 24'sd200, 24'sd300},
          1'b1, '{24'sd0, 24'sd0, 24'sd0, 27'd0, 1'b0}},
        '{'{MODE_POINT, 17'd32768, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX,
            CMIN}, 1'b0, '0},
        '{'{MODE_POINT, 17'd1, 24'sd1000, -24'sd1000, 24'sd7, 24'sd3, 24'sd9, -24'sd4,
            24'sd2, -24'sd1000, 24'sd1000, -24'sd7}, 1'b0, '0},
        '{'{MODE_POINT, 17'd65535, 24'sd1000, -24'sd1000, 24'sd7, 24'sd3, 24'sd9,
            -24'sd4, 24'sd2, -24'sd1000, 24'sd1000, -24'sd7}, 1'b0, '0},
        '{'{MODE_POINT, 17'd32768, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
            CMAX}, 1'b0, '0},
        '{'{MODE_POINT, 17'd32768, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
            CMIN}, 1'b0, '0},
        '{'{MODE_LENGTH, 17'd0, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX,
            CMAX}, 1'b0, '0},
        '{'{MODE_LENGTH, 17'h1FFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd5000, 24'sd0, 24'sd10000,
            24'sd0, 24'sd15000, 24'sd0, 24'sd0}, 1'b0, '0},
        '{'{MODE_LENGTH, 17'd12345, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN,
            CMAX, CMAX}, 1'b0, '0}
    };

    // rounded, saturated Bezier coordinate at Q1.16 parameter t
    function automatic logic signed [COORD_W-1:0] bez_axis(longint t, longint p0,
                                                           longint p1, longint p2, longint p3);
        longint u, w0, w1, w2, w3, acc, r;
        u   = ONE_Q16 - t;
        w0  = (u * u * u + 64'h80000000) >>> 32;
        w1  = (3 * t * u * u + 64'h80000000) >>> 32;
        w2  = (3 * t * t * u + 64'h80000000) >>> 32;
        w3  = (t * t * t + 64'h80000000) >>> 32;
        acc = p0 * w0 + p1 * w1 + p2 * w2 + p3 * w3;
        r   = (acc + 32768) >>> 16;
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[COORD_W-1:0];
    endfunction

    function automatic longint chord_root(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic res_word_t predict_word(seg_word_t w);
        res_word_t r;
        longint t, ti, lx, ly, lz, nx, ny, nz, dx, dy, dz, total;
        r = '0;
        t = (w.t > T_ONE) ? ONE_Q16 : longint'(w.t);
        if (w.mode == MODE_POINT)
        begin
            r.px = bez_axis(t, w.sx, w.ax, w.bx, w.ex);
            r.py = bez_axis(t, w.sy, w.ay, w.by, w.ey);
            r.pz = bez_axis(t, w.sz, w.sz, w.sz, w.ez);
        end
        else
        begin
            lx = w.sx;
            ly = w.sy;
            lz = w.sz;
            total = 0;
            for (int i = 1; i <= CHORD_STEPS; i++)
            begin
                ti = (longint'(i) * ONE_Q16 + CHORD_STEPS / 2) / CHORD_STEPS;
                nx = bez_axis(ti, w.sx, w.ax, w.bx, w.ex);
                ny = bez_axis(ti, w.sy, w.ay, w.by, w.ey);
                nz = bez_axis(ti, w.sz, w.sz, w.sz, w.ez);
                dx = nx - lx;
                dy = ny - ly;
                dz = nz - lz;
                total = total + chord_root(dx * dx + dy * dy + dz * dz);
                if (total > 134217727)
                begin
                    total = 134217727;
                    r.sat = 1'b1;
                end
                lx = nx;
                ly = ny;
                lz = nz;
            end
            r.len = total[LEN_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // hand one segment word to the core, log its expectation when taken
    task automatic send_word(seg_word_t w, logic typed, res_word_t want);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            seg.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        seg.valid         <= 1'b1;
        seg.mode          <= w.mode;
        seg.t_fraction    <= w.t;
        seg.start_x       <= w.sx;
        seg.start_y       <= w.sy;
        seg.start_z       <= w.sz;
        seg.first_ctrl_x  <= w.ax;
        seg.first_ctrl_y  <= w.ay;
        seg.second_ctrl_x <= w.bx;
        seg.second_ctrl_y <= w.by;
        seg.end_x         <= w.ex;
        seg.end_y         <= w.ey;
        seg.end_z         <= w.ez;
        @(posedge clk);
        while (!(seg.valid && seg.ready))
            @(posedge clk);
        pending_results.push_back(typed ? want : predict_word(w));
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(bit near);
        if (near)
            return COORD_W'($signed($urandom_range(4000)) - 2000);
        case ($urandom_range(3))
            0: return CMAX;
            1: return CMIN;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic seg_word_t rand_word();
        seg_word_t w;
        bit near;
        near   = ($urandom_range(99) < 60);
        w.mode = ($urandom_range(99) < 20) ? MODE_LENGTH : MODE_POINT;
        case ($urandom_range(4))
            0: w.t = T_W'($urandom_range(131071, 65537));
            1: w.t = T_ONE;
            default: w.t = T_W'($urandom_range(65535));
        endcase
        w.sx = rand_coord(near);
        w.sy = rand_coord(near);
        w.sz = rand_coord(near);
        w.ax = rand_coord(near);
        w.ay = rand_coord(near);
        w.bx = rand_coord(near);
        w.by = rand_coord(near);
        w.ex = rand_coord(near);
        w.ey = rand_coord(near);
        w.ez = rand_coord(near);
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        res_word_t want;
        if (res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("result word with nothing pending at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.point_x !== want.px)
                    report_mismatch("point_x", res.point_x, want.px);
                if (res.point_y !== want.py)
                    report_mismatch("point_y", res.point_y, want.py);
                if (res.point_z !== want.pz)
                    report_mismatch("point_z", res.point_z, want.pz);
                if (res.curve_length !== want.len)
                    report_mismatch("curve_length", res.curve_length, want.len);
                if (res.length_saturated !== want.sat)
                    report_mismatch("length_saturated", res.length_saturated, want.sat);
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((seg.valid && seg.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** cubic_bezier_point_and_length_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        seg.valid         = 1'b0;
        seg.mode          = MODE_POINT;
        seg.t_fraction    = '0;
        seg.start_x       = '0;
        seg.start_y       = '0;
        seg.start_z       = '0;
        seg.first_ctrl_x  = '0;
        seg.first_ctrl_y  = '0;
        seg.second_ctrl_x = '0;
        seg.second_ctrl_y = '0;
        seg.end_x         = '0;
        seg.end_y         = '0;
        seg.end_z         = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 9;
        rx_idle_pct = 46;
        foreach (dir_tab[i])
            send_word(dir_tab[i].seg, dir_tab[i].typed, dir_tab[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
            begin
                tx_idle_pct = 46;
                rx_idle_pct = 9;
            end
            if (n == 2 * RANDOM_WORDS / 3)
            begin
                // hold off until the core has drained completely
                seg.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_word(rand_word(), 1'b0, '0);
        end
        seg.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("** cubic_bezier_point_and_length_core: PASSED **");
        else
            $display("** cubic_bezier_point_and_length_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// File: cubic_bezier_point_and_length_core.f
rtl/core/bcl_pkg.sv
rtl/core/bcl_seg_if.sv
rtl/core/bcl_res_if.sv
rtl/core/cubic_bezier_point_and_length_core.sv
bench/tb.sv
